FILE: rtl/core/four_axis_dda_step_ramp_generator_core_macros.svh
// assertion macros shared by the dda step ramp generator rtl
`ifndef FOUR_AXIS_DDA_STEP_RAMP_GENERATOR_CORE_MACROS_SVH
`define FOUR_AXIS_DDA_STEP_RAMP_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define FA_DDA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define FA_DDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/fa_dda_pkg.sv
// shared constants and codes of the dda step ramp generator
package fa_dda_pkg;

   localparam int STEP_BITS_DEF  = 24;
   localparam int AXES           = 4;
   localparam int AXIS_IDX_BITS  = 2;
   localparam int RAMP_BITS      = 8;
   localparam int STATUS_BITS    = 3;

   localparam logic [RAMP_BITS-1:0] RAMP_LIMIT_RESET = 8'd50;

   // response status codes
   localparam logic [STATUS_BITS-1:0] ST_STARTED    = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY      = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_STEPPED    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_IDLE_ADV   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_BUSY_START = 3'd4;

   // request kinds
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

endpackage

FILE: rtl/core/fa_dda_req_if.sv
// request channel: move commands and advance requests
interface fa_dda_req_if #(
   parameter int STEP_BITS = fa_dda_pkg::STEP_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [STEP_BITS-1:0]          steps_x;
   logic [STEP_BITS-1:0]          steps_y;
   logic [STEP_BITS-1:0]          steps_z;
   logic [STEP_BITS-1:0]          steps_e;
   logic [fa_dda_pkg::AXES-1:0]   dir_mask;
   logic [STEP_BITS-1:0]          min_delay_us;

   modport source (
      output valid, kind, steps_x, steps_y, steps_z, steps_e, dir_mask, min_delay_us,
      input  ready
   );
   modport sink (
      input  valid, kind, steps_x, steps_y, steps_z, steps_e, dir_mask, min_delay_us,
      output ready
   );
endinterface

FILE: rtl/core/fa_dda_rsp_if.sv
// response channel: status, step pulses and wait per transaction
interface fa_dda_rsp_if #(
   parameter int STEP_BITS = fa_dda_pkg::STEP_BITS_DEF
);
   logic                                valid;
   logic                                ready;
   logic [fa_dda_pkg::STATUS_BITS-1:0]  status;
   logic                                step_x;
   logic                                step_y;
   logic                                step_z;
   logic                                step_e;
   logic [fa_dda_pkg::AXES-1:0]         dir_out;
   logic [STEP_BITS:0]                  wait_us;
   logic                                last;

   modport source (
      output valid, status, step_x, step_y, step_z, step_e, dir_out, wait_us, last,
      input  ready
   );
   modport sink (
      input  valid, status, step_x, step_y, step_z, step_e, dir_out, wait_us, last,
      output ready
   );
endinterface

FILE: rtl/core/fa_dda_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module fa_dda_divider #(
   parameter int DW = fa_dda_pkg::STEP_BITS_DEF,
   parameter int VW = fa_dda_pkg::RAMP_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [VW:0]   shifted;
   logic [VW+1:0] trial;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(DW);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         // trial subtract decides one quotient bit
         if (!trial[VW+1]) begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/four_axis_dda_step_ramp_generator_core.sv
// four-axis dda stepper with linear speed ramp, one shared add/sub unit under a sequencer
// one transaction at a time: ready only while the sequencer is idle
// advance: from acceptance to response, one or two error steps per axis
//   plus one to five ramp-update steps, two index steps and the emit step
// start: axis scan, check and ramp steps, then, when the ramp is nonzero, a wait on the serial divider
// reset is synchronous: sequencer idle, no move active, ramp limit back to 50
`include "four_axis_dda_step_ramp_generator_core_macros.svh"

module four_axis_dda_step_ramp_generator_core #(
   parameter int STEP_BITS = fa_dda_pkg::STEP_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   fa_dda_req_if.sink                        req_if,
   fa_dda_rsp_if.source                      rsp_if,
   input  logic                              csr_we,
   input  logic [fa_dda_pkg::RAMP_BITS-1:0]  csr_wdata
);
   localparam int AXES = fa_dda_pkg::AXES;
   localparam int XW   = fa_dda_pkg::AXIS_IDX_BITS;
   localparam int RW   = fa_dda_pkg::RAMP_BITS;
   localparam int SW   = fa_dda_pkg::STATUS_BITS;
   localparam int WW   = STEP_BITS + 1;   // delay width
   localparam int EW   = STEP_BITS + 2;   // signed error term width
   localparam int AW   = STEP_BITS + 3;   // shared adder width, sign on top

   localparam logic [XW-1:0] AXIS_LAST = XW'(AXES - 1);

   // sequencer codes
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LONG     = 4'd1;
   localparam logic [3:0] S_CHK      = 4'd2;
   localparam logic [3:0] S_RAMP     = 4'd3;
   localparam logic [3:0] S_DIV_WAIT = 4'd4;
   localparam logic [3:0] S_ERR_SUB  = 4'd5;
   localparam logic [3:0] S_ERR_FIX  = 4'd6;
   localparam logic [3:0] S_R_IDX    = 4'd7;
   localparam logic [3:0] S_R_SEL    = 4'd8;
   localparam logic [3:0] S_R_ACC    = 4'd9;
   localparam logic [3:0] S_R_DCMP   = 4'd10;
   localparam logic [3:0] S_R_DADD   = 4'd11;
   localparam logic [3:0] S_R_DCLAMP = 4'd12;
   localparam logic [3:0] S_FIN1     = 4'd13;
   localparam logic [3:0] S_FIN2     = 4'd14;
   localparam logic [3:0] S_EMIT     = 4'd15;

   // control state
   logic [3:0]     state_ff, state_in;
   logic           busy_ff, busy_in;
   logic [RW-1:0]  ramp_limit_ff, ramp_limit_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // move state
   logic [STEP_BITS-1:0]        cnt_ff [AXES];
   logic [STEP_BITS-1:0]        cnt_in [AXES];
   logic signed [EW-1:0]        err_ff [AXES];
   logic signed [EW-1:0]        err_in [AXES];
   logic [STEP_BITS-1:0]        total_ff, total_in;
   logic [STEP_BITS-1:0]        iter_ff, iter_in;
   logic [STEP_BITS-1:0]        floor_ff, floor_in;
   logic [WW-1:0]               start_ff, start_in;
   logic [WW-1:0]               dstep_ff, dstep_in;
   logic [WW-1:0]               cur_ff, cur_in;
   logic [RW-1:0]               ramp_ff, ramp_in;
   logic [AXES-1:0]             dirs_ff, dirs_in;
   logic [XW-1:0]               axis_ff, axis_in;
   logic [AW-1:0]               tmp_ff, tmp_in;

   // response being built
   logic [SW-1:0]    res_status_ff, res_status_in;
   logic [AXES-1:0]  res_steps_ff, res_steps_in;
   logic [AXES-1:0]  res_dir_ff, res_dir_in;
   logic [WW-1:0]    res_wait_ff, res_wait_in;
   logic             res_last_ff, res_last_in;

   // output register
   logic [SW-1:0]    out_status_ff, out_status_in;
   logic [AXES-1:0]  out_steps_ff, out_steps_in;
   logic [AXES-1:0]  out_dir_ff, out_dir_in;
   logic [WW-1:0]    out_wait_ff, out_wait_in;
   logic             out_last_ff, out_last_in;

   // shared add/sub unit
   logic [AW-1:0]    alu_a, alu_b, alu_res;
   logic             alu_sub, alu_neg;

   // divider hookup
   logic                 div_start, div_done;
   logic [RW-1:0]        div_divisor;
   logic [STEP_BITS-1:0] div_quot;

   logic [STEP_BITS-1:0] half;
   logic                 req_fire, emit_load;

   assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign alu_neg = alu_res[AW-1];
   assign half    = total_ff >> 1;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign emit_load    = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_if.ready);

   fa_dda_divider #(
      .DW (STEP_BITS),
      .VW (RW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (floor_ff),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      ramp_limit_in = csr_we ? csr_wdata : ramp_limit_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      total_in      = total_ff;
      iter_in       = iter_ff;
      floor_in      = floor_ff;
      start_in      = start_ff;
      dstep_in      = dstep_ff;
      cur_in        = cur_ff;
      ramp_in       = ramp_ff;
      dirs_in       = dirs_ff;
      axis_in       = axis_ff;
      tmp_in        = tmp_ff;
      res_status_in = res_status_ff;
      res_steps_in  = res_steps_ff;
      res_dir_in    = res_dir_ff;
      res_wait_in   = res_wait_ff;
      res_last_in   = res_last_ff;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b1;
      div_start     = 1'b0;
      div_divisor   = ramp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_steps_in = '0;
               res_wait_in  = '0;
               res_last_in  = 1'b0;
               res_dir_in   = '0;
               if (req_if.kind == fa_dda_pkg::KIND_ADVANCE) begin
                  if (!busy_ff) begin
                     res_status_in = fa_dda_pkg::ST_IDLE_ADV;
                     state_in      = S_EMIT;
                  end else begin
                     // wait reported is the delay in force before this iteration
                     res_status_in = fa_dda_pkg::ST_STEPPED;
                     res_dir_in    = dirs_ff;
                     res_wait_in   = cur_ff;
                     axis_in       = '0;
                     state_in      = S_ERR_SUB;
                  end
               end else if (busy_ff) begin
                  res_status_in = fa_dda_pkg::ST_BUSY_START;
                  res_dir_in    = dirs_ff;
                  state_in      = S_EMIT;
               end else begin
                  // idle: latching over stale move state is harmless
                  cnt_in[0] = req_if.steps_x;
                  cnt_in[1] = req_if.steps_y;
                  cnt_in[2] = req_if.steps_z;
                  cnt_in[3] = req_if.steps_e;
                  floor_in  = req_if.min_delay_us;
                  start_in  = {req_if.min_delay_us, 1'b0};
                  dirs_in   = req_if.dir_mask;
                  res_dir_in = req_if.dir_mask;
                  total_in  = '0;
                  axis_in   = '0;
                  state_in  = S_LONG;
               end
            end
         end

         S_LONG: begin
            // running maximum of the axis counts
            alu_a = AW'(cnt_ff[axis_ff]);
            alu_b = AW'(total_ff);
            if (!alu_neg) begin
               total_in = cnt_ff[axis_ff];
            end
            axis_in = axis_ff + XW'(1);
            if (axis_ff == AXIS_LAST) begin
               state_in = S_CHK;
            end
         end

         S_CHK: begin
            if (total_ff == '0) begin
               res_status_in = fa_dda_pkg::ST_EMPTY;
               state_in      = S_EMIT;
            end else begin
               for (int i = 0; i < AXES; i++) begin
                  err_in[i] = EW'(half);
               end
               iter_in  = '0;
               cur_in   = start_ff;
               busy_in  = 1'b1;
               state_in = S_RAMP;
            end
         end

         S_RAMP: begin
            // ramp length = min(longest / 2, limit)
            alu_a = AW'(half);
            alu_b = AW'(ramp_limit_ff);
            ramp_in = alu_neg ? half[RW-1:0] : ramp_limit_ff;
            res_status_in = fa_dda_pkg::ST_STARTED;
            if (ramp_in == '0) begin
               dstep_in = '0;
               state_in = S_EMIT;
            end else begin
               div_start   = 1'b1;
               div_divisor = ramp_in;
               state_in    = S_DIV_WAIT;
            end
         end

         S_DIV_WAIT: begin
            // start minus cruise equals cruise, so divide the cruise delay
            if (div_done) begin
               dstep_in = WW'(div_quot);
               state_in = S_EMIT;
            end
         end

         S_ERR_SUB: begin
            if (cnt_ff[axis_ff] == '0) begin
               axis_in  = axis_ff + XW'(1);
               state_in = (axis_ff == AXIS_LAST) ? S_R_IDX : S_ERR_SUB;
            end else begin
               alu_a = AW'(err_ff[axis_ff]);
               alu_b = AW'(cnt_ff[axis_ff]);
               err_in[axis_ff] = alu_res[EW-1:0];
               state_in = S_ERR_FIX;
            end
         end

         S_ERR_FIX: begin
            alu_a   = AW'(err_ff[axis_ff]);
            alu_b   = AW'(total_ff);
            alu_sub = 1'b0;
            if (err_ff[axis_ff] < 0) begin
               err_in[axis_ff]       = alu_res[EW-1:0];
               res_steps_in[axis_ff] = 1'b1;
            end
            axis_in  = axis_ff + XW'(1);
            state_in = (axis_ff == AXIS_LAST) ? S_R_IDX : S_ERR_SUB;
         end

         S_R_IDX: begin
            alu_a    = AW'(iter_ff);
            alu_b    = AW'(ramp_ff);
            tmp_in   = alu_res;
            state_in = (ramp_ff == '0) ? S_FIN1 : S_R_SEL;
         end

         S_R_SEL: begin
            if (tmp_ff[AW-1]) begin
               // accelerating: try current - step
               alu_a    = AW'(cur_ff);
               alu_b    = AW'(dstep_ff);
               state_in = S_R_ACC;
            end else begin
               // decel region starts at total - ramp
               alu_a    = AW'(total_ff);
               alu_b    = AW'(ramp_ff);
               state_in = S_R_DCMP;
            end
            tmp_in = alu_res;
         end

         S_R_ACC: begin
            alu_a    = tmp_ff;
            alu_b    = AW'(floor_ff);
            cur_in   = alu_neg ? WW'(floor_ff) : tmp_ff[WW-1:0];
            state_in = S_FIN1;
         end

         S_R_DCMP: begin
            alu_a    = AW'(iter_ff);
            alu_b    = tmp_ff;
            state_in = alu_neg ? S_FIN1 : S_R_DADD;
         end

         S_R_DADD: begin
            alu_a    = AW'(cur_ff);
            alu_b    = AW'(dstep_ff);
            alu_sub  = 1'b0;
            tmp_in   = alu_res;
            state_in = S_R_DCLAMP;
         end

         S_R_DCLAMP: begin
            alu_a    = AW'(start_ff);
            alu_b    = tmp_ff;
            cur_in   = alu_neg ? start_ff : tmp_ff[WW-1:0];
            state_in = S_FIN1;
         end

         S_FIN1: begin
            alu_a    = AW'(iter_ff);
            alu_b    = AW'(1);
            alu_sub  = 1'b0;
            iter_in  = alu_res[STEP_BITS-1:0];
            state_in = S_FIN2;
         end

         S_FIN2: begin
            alu_a = AW'(iter_ff);
            alu_b = AW'(total_ff);
            if (!alu_neg) begin
               res_last_in = 1'b1;
               busy_in     = 1'b0;
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (emit_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register, held until the consumer takes the transaction
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_status_in = out_status_ff;
      out_steps_in  = out_steps_ff;
      out_dir_in    = out_dir_ff;
      out_wait_in   = out_wait_ff;
      out_last_in   = out_last_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_load) begin
         rsp_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_steps_in  = res_steps_ff;
         out_dir_in    = res_dir_ff;
         out_wait_in   = res_wait_ff;
         out_last_in   = res_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= 1'b0;
         ramp_limit_ff <= fa_dda_pkg::RAMP_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         ramp_limit_ff <= ramp_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      err_ff        <= err_in;
      total_ff      <= total_in;
      iter_ff       <= iter_in;
      floor_ff      <= floor_in;
      start_ff      <= start_in;
      dstep_ff      <= dstep_in;
      cur_ff        <= cur_in;
      ramp_ff       <= ramp_in;
      dirs_ff       <= dirs_in;
      axis_ff       <= axis_in;
      tmp_ff        <= tmp_in;
      res_status_ff <= res_status_in;
      res_steps_ff  <= res_steps_in;
      res_dir_ff    <= res_dir_in;
      res_wait_ff   <= res_wait_in;
      res_last_ff   <= res_last_in;
      out_status_ff <= out_status_in;
      out_steps_ff  <= out_steps_in;
      out_dir_ff    <= out_dir_in;
      out_wait_ff   <= out_wait_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.status  = out_status_ff;
   assign rsp_if.step_x  = out_steps_ff[0];
   assign rsp_if.step_y  = out_steps_ff[1];
   assign rsp_if.step_z  = out_steps_ff[2];
   assign rsp_if.step_e  = out_steps_ff[3];
   assign rsp_if.dir_out = out_dir_ff;
   assign rsp_if.wait_us = out_wait_ff;
   assign rsp_if.last    = out_last_ff;

   // the delay never leaves the band between cruise and start delay during a move
   `FA_DDA_ASSERT_NOW(a_delay_band, busy_ff && (state_ff != S_CHK), (WW'(floor_ff) <= cur_ff) && (cur_ff <= start_ff), "current delay outside cruise/start band")

   // iteration index stays below the move length except right after the final increment
   `FA_DDA_ASSERT_NOW(a_iter_range, busy_ff && (state_ff != S_FIN2), iter_ff < total_ff, "iteration index ran past move length")

   // a last transaction means the move is closed
   `FA_DDA_ASSERT_NEXT(a_last_closes, emit_load && res_last_ff, !busy_ff && rsp_valid_ff && out_last_ff, "last transaction left move active")

   // the divider reports only while the sequencer waits for it
   `FA_DDA_ASSERT_NOW(a_div_done, div_done, state_ff == S_DIV_WAIT, "divider done outside wait state")

endmodule

FILE: verif/four_axis_dda_step_ramp_generator_core_test.sv
// testbench for the dda step ramp generator: scoreboard predictor, random moves, handshake stress
module four_axis_dda_step_ramp_generator_core_test;

   localparam int SB = fa_dda_pkg::STEP_BITS_DEF;
   localparam int AXES = fa_dda_pkg::AXES;
   localparam int RAMP_BITS = fa_dda_pkg::RAMP_BITS;
   localparam int STATUS_BITS = fa_dda_pkg::STATUS_BITS;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 225;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_OFF_CYCLES = 400;

   // one request transaction as seen on the input channel
   typedef struct packed {
      logic          kind;
      logic [SB-1:0] steps_x;
      logic [SB-1:0] steps_y;
      logic [SB-1:0] steps_z;
      logic [SB-1:0] steps_e;
      logic [3:0]    dir_mask;
      logic [SB-1:0] min_delay_us;
   } dda_req_type;

   // one response transaction as seen on the result channel
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   step_x;
      logic                   step_y;
      logic                   step_z;
      logic                   step_e;
      logic [3:0]             dir_out;
      logic [SB:0]            wait_us;
      logic                   last;
   } dda_rsp_type;

   // move tracker: mirrors the stepper state and holds the responses still to come
   class dda_scoreboard_type;
      logic [RAMP_BITS-1:0]  ramp_limit;
      logic [SB-1:0]         axis_count [AXES];
      logic signed [SB+1:0]  axis_err [AXES];
      logic [SB-1:0]         move_len;
      logic [SB-1:0]         iter_idx;
      logic [SB-1:0]         floor_dly;
      logic [SB:0]           start_dly;
      logic [SB:0]           dly_step;
      logic [SB:0]           cur_dly;
      logic [RAMP_BITS-1:0]  ramp_len;
      logic [3:0]            move_dirs;
      bit                    busy;
      dda_rsp_type           awaited_rsp [$];
      int                    errors;
      int                    n_started, n_empty, n_stepped, n_idle_adv, n_busy_start, n_moves_done;

      function new();
         ramp_limit = fa_dda_pkg::RAMP_LIMIT_RESET;
         for (int a = 0; a < AXES; a++) begin
            axis_count[a] = '0;
            axis_err[a] = '0;
         end
         move_len = '0;
         iter_idx = '0;
         floor_dly = '0;
         start_dly = '0;
         dly_step = '0;
         cur_dly = '0;
         ramp_len = '0;
         move_dirs = '0;
         busy = 0;
         errors = 0;
         n_started = 0;
         n_empty = 0;
         n_stepped = 0;
         n_idle_adv = 0;
         n_busy_start = 0;
         n_moves_done = 0;
      endfunction

      // updates the move state for one request and returns the response it causes
      function dda_rsp_type move_response(dda_req_type r);
         dda_rsp_type   o;
         logic [SB-1:0] cnt [AXES];
         logic [SB-1:0] longest;
         logic [SB-1:0] half;
         logic [3:0]    stp;
         logic [SB+1:0] wide;
         o = '0;
         stp = '0;
         if (r.kind == fa_dda_pkg::KIND_START) begin
            if (busy) begin
               o.status = fa_dda_pkg::ST_BUSY_START;
               o.dir_out = move_dirs;
               return o;
            end
            cnt[0] = r.steps_x;
            cnt[1] = r.steps_y;
            cnt[2] = r.steps_z;
            cnt[3] = r.steps_e;
            longest = '0;
            for (int a = 0; a < AXES; a++)
               if (cnt[a] > longest) longest = cnt[a];
            o.dir_out = r.dir_mask;
            if (longest == 0) begin
               o.status = fa_dda_pkg::ST_EMPTY;
               return o;
            end
            half = longest >> 1;
            for (int a = 0; a < AXES; a++) begin
               axis_count[a] = cnt[a];
               axis_err[a] = $signed({2'b00, half});
            end
            move_len = longest;
            iter_idx = '0;
            floor_dly = r.min_delay_us;
            start_dly = {r.min_delay_us, 1'b0};
            if (half > ramp_limit) ramp_len = ramp_limit;
            else ramp_len = half[RAMP_BITS-1:0];
            if (ramp_len != 0) dly_step = (start_dly - {1'b0, floor_dly}) / ramp_len;
            else dly_step = '0;
            cur_dly = start_dly;
            move_dirs = r.dir_mask;
            busy = 1;
            o.status = fa_dda_pkg::ST_STARTED;
            return o;
         end
         if (!busy) begin
            o.status = fa_dda_pkg::ST_IDLE_ADV;
            return o;
         end
         for (int a = 0; a < AXES; a++) begin
            if (axis_count[a] != 0) begin
               axis_err[a] = axis_err[a] - $signed({2'b00, axis_count[a]});
               if (axis_err[a] < 0) begin
                  axis_err[a] = axis_err[a] + $signed({2'b00, move_len});
                  stp[a] = 1'b1;
               end
            end
         end
         o.status = fa_dda_pkg::ST_STEPPED;
         o.step_x = stp[0];
         o.step_y = stp[1];
         o.step_z = stp[2];
         o.step_e = stp[3];
         o.dir_out = move_dirs;
         o.wait_us = cur_dly;
         if (ramp_len != 0) begin
            if (iter_idx < ramp_len) begin
               if ({1'b0, cur_dly} >= {2'b00, floor_dly} + {1'b0, dly_step})
                  cur_dly = cur_dly - dly_step;
               else
                  cur_dly = {1'b0, floor_dly};
            end else if (iter_idx >= move_len - ramp_len) begin
               wide = {1'b0, cur_dly} + {1'b0, dly_step};
               if (wide > {1'b0, start_dly}) cur_dly = start_dly;
               else cur_dly = wide[SB:0];
            end
         end
         iter_idx = iter_idx + 1'b1;
         if (iter_idx >= move_len) begin
            o.last = 1'b1;
            busy = 0;
         end
         return o;
      endfunction

      function void note_request(dda_req_type r);
         awaited_rsp.push_back(move_response(r));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(dda_rsp_type got);
         dda_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $error("response transaction with none outstanding");
            errors++;
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("step_x", 32'(want.step_x), 32'(got.step_x));
         compare_field("step_y", 32'(want.step_y), 32'(got.step_y));
         compare_field("step_z", 32'(want.step_z), 32'(got.step_z));
         compare_field("step_e", 32'(want.step_e), 32'(got.step_e));
         compare_field("dir_out", 32'(want.dir_out), 32'(got.dir_out));
         compare_field("wait_us", 32'(want.wait_us), 32'(got.wait_us));
         compare_field("last", 32'(want.last), 32'(got.last));
         unique case (want.status)
            fa_dda_pkg::ST_STARTED:    n_started++;
            fa_dda_pkg::ST_EMPTY:      n_empty++;
            fa_dda_pkg::ST_STEPPED:    n_stepped++;
            fa_dda_pkg::ST_IDLE_ADV:   n_idle_adv++;
            default:                   n_busy_start++;
         endcase
         if (want.last) n_moves_done++;
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [RAMP_BITS-1:0] csr_wdata;

   fa_dda_req_if #(.STEP_BITS(SB)) req_ch ();
   fa_dda_rsp_if #(.STEP_BITS(SB)) rsp_ch ();

   four_axis_dda_step_ramp_generator_core #(.STEP_BITS(SB)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   dda_scoreboard_type sb;

   // traffic shaping knobs, changed by the main sequence right after a falling edge
   int send_idle_pct;
   int stall_pct;
   int rsp_hold_cycles;
   // advances still owed to the move the generator last started
   int moves_left;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // watchdog: far beyond the slowest legal run
   initial begin
      #(12 * 1000000);
      $display("FAIL");
      $finish;
   end

   // receiver: random stalls, or a long counted hold-off when one is requested
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // monitor: note requests and check responses on the transaction edges
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_request({req_ch.kind, req_ch.steps_x, req_ch.steps_y, req_ch.steps_z,
                             req_ch.steps_e, req_ch.dir_mask, req_ch.min_delay_us});
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response({rsp_ch.status, rsp_ch.step_x, rsp_ch.step_y, rsp_ch.step_z,
                               rsp_ch.step_e, rsp_ch.dir_out, rsp_ch.wait_us, rsp_ch.last});
      end
   end

   function automatic dda_req_type start_item(logic [SB-1:0] x, logic [SB-1:0] y,
                                              logic [SB-1:0] z, logic [SB-1:0] e,
                                              logic [3:0] dirs, logic [SB-1:0] cruise);
      dda_req_type it;
      it.kind = fa_dda_pkg::KIND_START;
      it.steps_x = x;
      it.steps_y = y;
      it.steps_z = z;
      it.steps_e = e;
      it.dir_mask = dirs;
      it.min_delay_us = cruise;
      return it;
   endfunction

   // advance with random filler in the fields the block does not use
   function automatic dda_req_type advance_item();
      dda_req_type it;
      it = start_item(SB'($urandom), SB'($urandom), SB'($urandom), SB'($urandom),
                      4'($urandom), SB'($urandom));
      it.kind = fa_dda_pkg::KIND_ADVANCE;
      return it;
   endfunction

   // offer one request, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_req(input dda_req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.kind <= it.kind;
      req_ch.steps_x <= it.steps_x;
      req_ch.steps_y <= it.steps_y;
      req_ch.steps_z <= it.steps_z;
      req_ch.steps_e <= it.steps_e;
      req_ch.dir_mask <= it.dir_mask;
      req_ch.min_delay_us <= it.min_delay_us;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop offering, let every outstanding response arrive, then let the sequencer settle
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ramp_limit(input logic [RAMP_BITS-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.ramp_limit = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // random traffic: mostly complete moves, with idle advances, empty moves and busy starts
   task automatic run_random(input int n);
      int            done;
      int            pick;
      int            len;
      int            main_axis;
      logic [SB-1:0] cnt [AXES];
      logic [SB-1:0] cruise;
      dda_req_type   it;
      done = 0;
      while (done < n) begin
         pick = $urandom_range(99);
         if (moves_left > 0) begin
            if (pick < 8) begin
               // start while busy: ignored, so any field value is fair
               it = start_item(SB'($urandom), SB'($urandom), SB'($urandom), SB'($urandom),
                               4'($urandom), SB'($urandom));
            end else begin
               it = advance_item();
               moves_left--;
            end
         end else if (pick < 7) begin
            it = advance_item();
         end else if (pick < 15) begin
            it = start_item('0, '0, '0, '0, 4'($urandom), SB'($urandom));
         end else begin
            pick = $urandom_range(99);
            if (pick < 75) len = $urandom_range(30, 1);
            else if (pick < 95) len = $urandom_range(120, 31);
            else len = $urandom_range(530, 511);
            main_axis = $urandom_range(AXES - 1);
            for (int a = 0; a < AXES; a++) begin
               if (a == main_axis) cnt[a] = SB'(len);
               else if ($urandom_range(3) == 0) cnt[a] = '0;
               else cnt[a] = SB'($urandom_range(len));
            end
            pick = $urandom_range(99);
            if (pick < 10) cruise = '0;
            else if (pick < 20) cruise = SB'($urandom);
            else cruise = SB'($urandom_range(2000, 1));
            it = start_item(cnt[0], cnt[1], cnt[2], cnt[3], 4'($urandom), cruise);
            moves_left = len;
         end
         done++;
         send_req(it);
      end
   endtask

   initial begin
      int                   idle_by_mode [4];
      int                   stall_by_mode [4];
      logic [RAMP_BITS-1:0] limits [PHASES];

      idle_by_mode = '{0, 60, 0, 16};
      stall_by_mode = '{0, 0, 60, 16};
      limits = '{8'd0, 8'd255, 8'd1, RAMP_BITS'($urandom_range(254, 2)), 8'd3, 8'd0, 8'd255,
                 RAMP_BITS'($urandom_range(254, 2))};

      sb = new();
      send_idle_pct = 0;
      stall_pct = 0;
      rsp_hold_cycles = 0;
      moves_left = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = fa_dda_pkg::KIND_START;
      req_ch.steps_x = '0;
      req_ch.steps_y = '0;
      req_ch.steps_z = '0;
      req_ch.steps_e = '0;
      req_ch.dir_mask = '0;
      req_ch.min_delay_us = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, ramp limit still at its reset value
      // advance with no move active
      send_req(advance_item());
      // all counts zero: empty move, no move started
      send_req(start_item('0, '0, '0, '0, 4'hF, '1));
      // short move with a two-step ramp
      send_req(start_item(24'd5, 24'd3, 24'd0, 24'd5, 4'b1010, 24'd100));
      // start while busy, fields at both extremes
      send_req(start_item('1, '1, '1, '1, 4'hF, '1));
      send_req(start_item('0, '0, '0, '0, 4'h0, '0));
      repeat (5) send_req(advance_item());
      send_req(advance_item());
      // zero cruise delay: every wait is zero
      send_req(start_item(24'd4, 24'd0, 24'd2, 24'd1, 4'b0101, 24'd0));
      repeat (4) send_req(advance_item());
      // one-iteration move: no ramp, wait at twice the largest cruise
      send_req(start_item('0, '0, '0, 24'd1, 4'b1000, '1));
      send_req(advance_item());
      // cruise not divisible by the ramp: the truncated step leaves the delay above the floor
      send_req(start_item(24'd5, 24'd2, 24'd0, 24'd5, 4'hF, 24'd7));
      repeat (5) send_req(advance_item());

      // random phases, each with its own ramp limit and traffic shape
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         // a move may still be open here: the new limit must only apply at its next start
         write_ramp_limit(limits[p]);
         send_idle_pct = idle_by_mode[p % 4];
         stall_pct = stall_by_mode[p % 4];
         // long receiver hold-off while the sender keeps offering, so the input backs up
         if (p == 0) rsp_hold_cycles = HOLD_OFF_CYCLES;
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      $display("covered %0d starts, %0d iterations, %0d completed moves, %0d empty moves",
               sb.n_started, sb.n_stepped, sb.n_moves_done, sb.n_empty);
      $display("plus %0d idle advances and %0d busy starts over %0d ramp limit settings",
               sb.n_idle_adv, sb.n_busy_start, PHASES + 1);
      if (sb.errors == 0 && sb.awaited_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: four_axis_dda_step_ramp_generator_core.f
+incdir+rtl/core
rtl/core/fa_dda_pkg.sv
rtl/core/fa_dda_req_if.sv
rtl/core/fa_dda_rsp_if.sv
rtl/core/fa_dda_divider.sv
rtl/core/four_axis_dda_step_ramp_generator_core.sv
verif/four_axis_dda_step_ramp_generator_core_test.sv
